/* sv/tmt32_pkg.sv */
`default_nettype none

package tmt32_pkg;

   localparam int unsigned WORD_W = 32;
   localparam int unsigned CNT_W = 5;
   localparam int unsigned CSR_IDX_W = 2;

   localparam int unsigned INIT_ROUNDS_DEF = 8;
   localparam int unsigned DISCARD_COUNT_DEF = 8;

   localparam logic [WORD_W-1:0] MULT_CONST = 32'd1812433253;
   localparam logic [WORD_W-1:0] LOW31_MASK = 32'h7FFF_FFFF;

   localparam logic [WORD_W-1:0] MAT1_RESET = 32'h8F70_11EE;
   localparam logic [WORD_W-1:0] MAT2_RESET = 32'hFC78_FF1F;
   localparam logic [WORD_W-1:0] TMAT_RESET = 32'h3793_FDFF;

   localparam logic [WORD_W-1:0] FIX_WORD0 = 32'h0000_0054;
   localparam logic [WORD_W-1:0] FIX_WORD1 = 32'h0000_0049;
   localparam logic [WORD_W-1:0] FIX_WORD2 = 32'h0000_004E;
   localparam logic [WORD_W-1:0] FIX_WORD3 = 32'h0000_0059;

   localparam logic REQ_CMD_NEXT = 1'b0;
   localparam logic REQ_CMD_SEED = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAT1 = 2'd0,
      CSR_MAT2 = 2'd1,
      CSR_TMAT = 2'd2,
      CSR_NONE = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_ADD,
      ST_ALIGN,
      ST_FIX,
      ST_DISCARD
   } ctrl_state_type;

   typedef logic [3:0][WORD_W-1:0] words_type;

   typedef struct packed {
      logic             load_seed;
      logic             mul;
      logic             add;
      logic             align;
      logic             fix;
      logic             step;
      logic             out_load;
      logic [CNT_W-1:0] round_idx;
   } ctrl_cmd_type;

   typedef struct packed {
      words_type         words;
      logic [WORD_W-1:0] value;
   } step_type;

   function automatic step_type tmt_step(
      input words_type         s,
      input logic [WORD_W-1:0] m1,
      input logic [WORD_W-1:0] m2,
      input logic [WORD_W-1:0] tm
   );
      logic [WORD_W-1:0] x;
      logic [WORD_W-1:0] y;
      logic [WORD_W-1:0] sum;
      step_type          r;
      x = (s[0] & LOW31_MASK) ^ s[1] ^ s[2];
      y = s[3];
      x = x ^ (x << 1);
      y = y ^ (y >> 1) ^ x;
      r.words[0] = s[1];
      r.words[1] = s[2];
      r.words[2] = x ^ (y << 10);
      r.words[3] = y;
      if (y[0]) begin
         r.words[1] = r.words[1] ^ m1;
         r.words[2] = r.words[2] ^ m2;
      end
      sum = r.words[0] + (r.words[2] >> 8);
      r.value = r.words[3] ^ sum;
      if (sum[0]) begin
         r.value = r.value ^ tm;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

/* sv/tmt32_ctrl.sv */
`default_nettype none

module tmt32_ctrl
   import tmt32_pkg::*;
#(
   parameter int unsigned INIT_ROUNDS = INIT_ROUNDS_DEF,
   parameter int unsigned DISCARD_COUNT = DISCARD_COUNT_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire logic         req_cmd,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output ctrl_cmd_type      cmd
);

   localparam logic [CNT_W-1:0] LAST_ROUND = CNT_W'(INIT_ROUNDS - 1);
   localparam logic [CNT_W-1:0] DISCARD_END = CNT_W'(DISCARD_COUNT);

   ctrl_state_type   state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] count_inc;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             accept;

   assign count_inc = count_ff + CNT_W'(1);
   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // The words have been rotated count - 1 times once count is updated, so
   // they are back in place when the new count is one modulo four.
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd = '0;
      cmd.round_idx = count_ff;
      unique case (state_ff)
         ST_IDLE: begin
            count_in = '0;
            if (accept) begin
               if (req_cmd == REQ_CMD_SEED) begin
                  cmd.load_seed = 1'b1;
                  count_in = CNT_W'(1);
                  state_in = ST_MUL;
               end else begin
                  cmd.step = 1'b1;
                  cmd.out_load = 1'b1;
                  rsp_valid_in = 1'b1;
               end
            end
         end
         ST_MUL: begin
            cmd.mul = 1'b1;
            state_in = ST_ADD;
         end
         ST_ADD: begin
            cmd.add = 1'b1;
            count_in = count_inc;
            if (count_ff == LAST_ROUND) begin
               state_in = (count_inc[1:0] == 2'd1) ? ST_FIX : ST_ALIGN;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_ALIGN: begin
            cmd.align = 1'b1;
            count_in = count_inc;
            if (count_inc[1:0] == 2'd1) begin
               state_in = ST_FIX;
            end
         end
         ST_FIX: begin
            cmd.fix = 1'b1;
            count_in = '0;
            state_in = (DISCARD_COUNT == 0) ? ST_IDLE : ST_DISCARD;
         end
         ST_DISCARD: begin
            cmd.step = 1'b1;
            count_in = count_inc;
            if (count_inc == DISCARD_END) begin
               count_in = '0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

/* sv/tmt32_dpath.sv */
`default_nettype none

module tmt32_dpath
   import tmt32_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [WORD_W-1:0]    csr_wdata,
   input  wire logic [WORD_W-1:0]    req_seed_value,
   input  wire ctrl_cmd_type         cmd,
   output logic [WORD_W-1:0]         rsp_random_value
);

   logic [WORD_W-1:0] mat1_ff, mat2_ff, tmat_ff;
   words_type         words_ff, words_in;
   logic [WORD_W-1:0] prod_ff;
   logic [WORD_W-1:0] mix;
   logic [WORD_W-1:0] out_ff;
   logic              all_zero;
   step_type          stepped;

   always_ff @(posedge clock) begin
      if (reset) begin
         mat1_ff <= MAT1_RESET;
         mat2_ff <= MAT2_RESET;
         tmat_ff <= TMAT_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_MAT1: mat1_ff <= csr_wdata;
            CSR_MAT2: mat2_ff <= csr_wdata;
            CSR_TMAT: tmat_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign stepped = tmt_step(words_ff, mat1_ff, mat2_ff, tmat_ff);
   assign mix = words_ff[0] ^ (words_ff[0] >> 30);
   assign all_zero = ((words_ff[0] & LOW31_MASK) == '0) && (words_ff[1] == '0) &&
                     (words_ff[2] == '0) && (words_ff[3] == '0);

   always_comb begin
      words_in = words_ff;
      if (cmd.load_seed) begin
         words_in[0] = req_seed_value;
         words_in[1] = mat1_ff;
         words_in[2] = mat2_ff;
         words_in[3] = tmat_ff;
      end else if (cmd.add) begin
         words_in[0] = words_ff[1] ^ (prod_ff + WORD_W'(cmd.round_idx));
         words_in[1] = words_ff[2];
         words_in[2] = words_ff[3];
         words_in[3] = words_ff[0];
      end else if (cmd.align) begin
         words_in[0] = words_ff[1];
         words_in[1] = words_ff[2];
         words_in[2] = words_ff[3];
         words_in[3] = words_ff[0];
      end else if (cmd.fix) begin
         if (all_zero) begin
            words_in[0] = FIX_WORD0;
            words_in[1] = FIX_WORD1;
            words_in[2] = FIX_WORD2;
            words_in[3] = FIX_WORD3;
         end
      end else if (cmd.step) begin
         words_in = stepped.words;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         words_ff <= '0;
      end else begin
         words_ff <= words_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         prod_ff <= mix * MULT_CONST;
      end
      if (cmd.out_load) begin
         out_ff <= stepped.value;
      end
   end

   assign rsp_random_value = out_ff;

endmodule

`default_nettype wire

/* sv/tinymt32_generator_unit.sv */
// TinyMT32 pseudo-random generator with a 127-bit state in four words.
// The request channel (req_valid, req_ready, req_cmd, req_seed_value)
// takes commands: a next command advances the state one step and returns
// one tempered word on the response channel (rsp_valid, rsp_ready,
// rsp_random_value); a seed command reseeds and returns nothing.
// A next command transfer gives its result in the next cycle from the
// output register, and next commands are taken one per cycle while the
// receiver takes each result. A seed command keeps the block busy for
// INIT_ROUNDS-1 mixing rounds (a multiply step and an add step each), up to
// three realigning word rotations, one repair step and DISCARD_COUNT discard
// steps before the next transfer. The csr_ port writes mat1, mat2 or tmat,
// one per write; index three is ignored. Writes take effect on the next step;
// the user must write during idle only, as the block does not enforce it.
// Reset clears the state words to zero and restores the default
// parameters; next commands before any seed return zero.
// When the receiver stalls, the result is held and a new request is
// taken only in the cycle that the held result transfers.
`default_nettype none

module tinymt32_generator_unit
   import tmt32_pkg::*;
#(
   parameter int unsigned INIT_ROUNDS = INIT_ROUNDS_DEF,
   parameter int unsigned DISCARD_COUNT = DISCARD_COUNT_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [WORD_W-1:0]    csr_wdata,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic                 req_cmd,
   input  wire logic [WORD_W-1:0]    req_seed_value,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [WORD_W-1:0]         rsp_random_value
);

   ctrl_cmd_type cmd;

   tmt32_ctrl #(
      .INIT_ROUNDS(INIT_ROUNDS),
      .DISCARD_COUNT(DISCARD_COUNT)
   ) u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_cmd(req_cmd),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .cmd(cmd)
   );

   tmt32_dpath u_dpath (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_seed_value(req_seed_value),
      .cmd(cmd),
      .rsp_random_value(rsp_random_value)
   );

endmodule

`default_nettype wire

/* sim/tinymt32_result_checker.sv */
`timescale 1ns / 1ps

module tinymt32_result_checker
   import tmt32_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [WORD_W-1:0]    csr_wdata,
   input  wire logic                 req_valid,
   input  wire logic                 req_ready,
   input  wire logic                 req_cmd,
   input  wire logic [WORD_W-1:0]    req_seed_value,
   input  wire logic                 rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire logic [WORD_W-1:0]    rsp_random_value,
   output int                        mismatch_count,
   output int                        outstanding
);

   logic [WORD_W-1:0] gen_word [4];
   logic [WORD_W-1:0] mat1_q;
   logic [WORD_W-1:0] mat2_q;
   logic [WORD_W-1:0] tmat_q;
   logic [WORD_W-1:0] expected_words [$];
   logic [WORD_W-1:0] oldest_word;

   function automatic logic [WORD_W-1:0] advance_state();
      logic [WORD_W-1:0] x;
      logic [WORD_W-1:0] y;
      logic [WORD_W-1:0] sum;
      x = (gen_word[0] & LOW31_MASK) ^ gen_word[1] ^ gen_word[2];
      y = gen_word[3];
      x = x ^ (x << 1);
      y = y ^ (y >> 1) ^ x;
      gen_word[0] = gen_word[1];
      gen_word[1] = gen_word[2] ^ (y[0] ? mat1_q : '0);
      gen_word[2] = x ^ (y << 10) ^ (y[0] ? mat2_q : '0);
      gen_word[3] = y;
      sum = gen_word[0] + (gen_word[2] >> 8);
      return y ^ sum ^ (sum[0] ? tmat_q : '0);
   endfunction

   task automatic seed_state(input logic [WORD_W-1:0] seed);
      logic [WORD_W-1:0] prev;
      gen_word[0] = seed;
      gen_word[1] = mat1_q;
      gen_word[2] = mat2_q;
      gen_word[3] = tmat_q;
      for (int unsigned r = 1; r < INIT_ROUNDS_DEF; r++) begin
         prev = gen_word[(r - 1) % 4];
         prev = prev ^ (prev >> 30);
         gen_word[r % 4] = gen_word[r % 4] ^ (prev * MULT_CONST + WORD_W'(r));
      end
      if ((gen_word[0] & LOW31_MASK) == '0 && gen_word[1] == '0 &&
          gen_word[2] == '0 && gen_word[3] == '0) begin
         gen_word[0] = FIX_WORD0;
         gen_word[1] = FIX_WORD1;
         gen_word[2] = FIX_WORD2;
         gen_word[3] = FIX_WORD3;
      end
      repeat (DISCARD_COUNT_DEF) void'(advance_state());
   endtask

   always @(posedge clock) begin
      if (reset) begin
         mat1_q = MAT1_RESET;
         mat2_q = MAT2_RESET;
         tmat_q = TMAT_RESET;
         for (int i = 0; i < 4; i++) gen_word[i] = '0;
         expected_words.delete();
         mismatch_count = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_MAT1: mat1_q = csr_wdata;
               CSR_MAT2: mat2_q = csr_wdata;
               CSR_TMAT: tmat_q = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               if (mismatch_count < 10) begin
                  $display("Unexpected result transfer: got %h", rsp_random_value);
               end
               mismatch_count++;
            end else begin
               oldest_word = expected_words.pop_front();
               if (rsp_random_value !== oldest_word) begin
                  if (mismatch_count < 10) begin
                     $display("Mismatch in random_value: expected %h, got %h",
                              oldest_word, rsp_random_value);
                  end
                  mismatch_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            if (req_cmd == REQ_CMD_SEED) begin
               seed_state(req_seed_value);
            end else begin
               expected_words.push_back(advance_state());
            end
         end
      end
      outstanding = expected_words.size();
   end

endmodule

/* sim/tinymt32_generator_unit_tb.sv */
`timescale 1ns / 1ps

module tinymt32_generator_unit_tb;
   import tmt32_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_ITEMS = 1900;
   localparam int PHASES = 6;
   localparam int SETTLE_CYCLES = 40;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_MAT1;
   logic [WORD_W-1:0]    csr_wdata = '0;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic                 req_cmd = REQ_CMD_NEXT;
   logic [WORD_W-1:0]    req_seed_value = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [WORD_W-1:0]    rsp_random_value;
   logic                 quiet = 1'b0;
   int                   mismatch_count;
   int                   outstanding;
   int                   cycles = 0;
   logic [WORD_W-1:0]    zero_seed;

   tinymt32_generator_unit dut (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_seed_value   (req_seed_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_random_value (rsp_random_value)
   );

   tinymt32_result_checker result_check (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_seed_value   (req_seed_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_random_value (rsp_random_value),
      .mismatch_count   (mismatch_count),
      .outstanding      (outstanding)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      rsp_ready <= quiet || ($urandom_range(99) >= 18);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   function automatic logic [WORD_W-1:0] spread(input logic [WORD_W-1:0] v);
      return (v ^ (v >> 30)) * MULT_CONST;
   endfunction

   function automatic logic [WORD_W-1:0] pick_seed();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         2: return 32'h8000_0000;
         default: return $urandom();
      endcase
   endfunction

   task automatic send_command(input logic cmd, input logic [WORD_W-1:0] seed);
      while (!quiet && $urandom_range(99) < 18) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_seed_value <= seed;
      @(negedge clock);
      while (!req_ready) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_params(input logic [WORD_W-1:0] m1, input logic [WORD_W-1:0] m2,
                               input logic [WORD_W-1:0] tm);
      csr_we <= 1'b1;
      csr_index <= CSR_MAT1;
      csr_wdata <= m1;
      @(posedge clock);
      csr_index <= CSR_MAT2;
      csr_wdata <= m2;
      @(posedge clock);
      csr_index <= CSR_TMAT;
      csr_wdata <= tm;
      @(posedge clock);
      csr_index <= CSR_NONE;
      csr_wdata <= $urandom();
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Work the mixing rounds backward so that the seeded state comes out all zero
   // apart from the top bit of word 0, which forces the fixed replacement state.
   task automatic setup_zero_state(input logic [WORD_W-1:0] final0,
                                   output logic [WORD_W-1:0] seed);
      logic [WORD_W-1:0] s1;
      logic [WORD_W-1:0] s2;
      logic [WORD_W-1:0] s3;
      s3 = spread('0) + 32'd7;
      s2 = spread('0) + 32'd6;
      s1 = spread(final0) + 32'd5;
      seed = final0 ^ (spread(s3) + 32'd4);
      write_params(s1 ^ (spread(seed) + 32'd1), s2 ^ (spread(s1) + 32'd2),
                   s3 ^ (spread(s2) + 32'd3));
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_command(REQ_CMD_NEXT, '0);
      send_command(REQ_CMD_NEXT, '1);
      send_command(REQ_CMD_NEXT, $urandom());
      send_command(REQ_CMD_SEED, '0);
      send_command(REQ_CMD_NEXT, '1);
      send_command(REQ_CMD_NEXT, '0);
      send_command(REQ_CMD_SEED, '1);
      send_command(REQ_CMD_NEXT, $urandom());
      send_command(REQ_CMD_SEED, 32'h8000_0000);
      send_command(REQ_CMD_NEXT, $urandom());
      send_command(REQ_CMD_SEED, 32'h7FFF_FFFF);
      send_command(REQ_CMD_NEXT, $urandom());
      wait_idle();
      write_params('1, '1, '1);
      send_command(REQ_CMD_SEED, $urandom());
      send_command(REQ_CMD_NEXT, $urandom());
      send_command(REQ_CMD_NEXT, $urandom());
      wait_idle();
      write_params('0, '0, '0);
      send_command(REQ_CMD_NEXT, $urandom());
      send_command(REQ_CMD_NEXT, $urandom());
      send_command(REQ_CMD_SEED, '0);
      send_command(REQ_CMD_NEXT, $urandom());
      wait_idle();
      setup_zero_state('0, zero_seed);
      send_command(REQ_CMD_SEED, zero_seed);
      send_command(REQ_CMD_NEXT, $urandom());
      send_command(REQ_CMD_NEXT, $urandom());
      wait_idle();
      setup_zero_state(32'h8000_0000, zero_seed);
      send_command(REQ_CMD_SEED, zero_seed);
      send_command(REQ_CMD_NEXT, $urandom());

      for (int phase = 0; phase < PHASES; phase++) begin
         wait_idle();
         quiet <= (phase == 3);
         case (phase)
            0: write_params(MAT1_RESET, MAT2_RESET, TMAT_RESET);
            1: write_params('1, '0, '1);
            2: write_params('0, '1, '0);
            default: write_params($urandom(), $urandom(), $urandom());
         endcase
         if (phase == 0 || $urandom_range(1) == 1) begin
            send_command(REQ_CMD_SEED, pick_seed());
         end
         for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
            if ($urandom_range(99) < 6) begin
               send_command(REQ_CMD_SEED, pick_seed());
            end else begin
               send_command(REQ_CMD_NEXT, $urandom());
            end
         end
      end

      wait_idle();
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
